### rtl/core/ssdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssdt_pkg;

  localparam int MAX_SECTIONS_DEF = 16;
  localparam int IDX_W   = 4;
  localparam int TICK_W  = 10;
  localparam int MON_W   = 11;
  localparam int MASK_W  = 16;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 11;

  typedef enum logic [CFG_A_W-1:0] {
    REG_OFF_HOLD_EN  = 3'd0,
    REG_OFF_HOLD_TK  = 3'd1,
    REG_MAP_ON_TK    = 3'd2,
    REG_LA_OFF_EN    = 3'd3,
    REG_MAP_OFF_LA   = 3'd4,
    REG_MAP_OFF_HOLD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                     off_hold_en;
    logic [TICK_W-1:0]        off_hold_ticks;
    logic signed [MON_W-1:0]  map_on_ticks;
    logic                     la_off_en;
    logic [TICK_W-1:0]        map_off_la;
    logic [TICK_W-1:0]        map_off_hold;
  } cfg_t;

  // per-section timer entry held in the timer memory
  typedef struct packed {
    logic [TICK_W-1:0]        hold;
    logic signed [MON_W-1:0]  map_on;
    logic [TICK_W-1:0]        map_off;
  } tmr_t;

  typedef struct packed {
    logic sec_on;
    logic map_on;
  } flg_t;

endpackage

`default_nettype wire

### rtl/core/ssdt_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ssdt_step (
  input  ssdt_pkg::cfg_t cfg,
  input  logic           on_req,
  input  ssdt_pkg::tmr_t tmr_i,
  input  ssdt_pkg::flg_t flg_i,
  output ssdt_pkg::tmr_t tmr_o,
  output ssdt_pkg::flg_t flg_o
);
  import ssdt_pkg::*;

  always_comb begin
    logic              son;
    logic              mp;
    logic [TICK_W-1:0] ht;
    logic signed [MON_W-1:0] mon;
    logic [TICK_W-1:0] moff;
    son  = flg_i.sec_on;
    mp   = flg_i.map_on;
    ht   = tmr_i.hold;
    mon  = tmr_i.map_on;
    moff = tmr_i.map_off;

    if (on_req) son = 1'b1;

    if (cfg.off_hold_en) begin
      if (on_req) ht = cfg.off_hold_ticks;
      if (ht != '0) ht = ht - TICK_W'(1);
      if (!on_req && ht == '0) son = 1'b0;
    end else if (!on_req) begin
      son = 1'b0;
    end

    if (on_req && !mp && mon == '0) begin
      mon = cfg.map_on_ticks;
    end else if (on_req && mp && moff > TICK_W'(1)) begin
      moff = '0;
      mon  = cfg.map_on_ticks;
    end

    if (cfg.la_off_en) begin
      if (!on_req && mp && moff == '0) moff = cfg.map_off_la;
    end else if (cfg.off_hold_en) begin
      if (!on_req && mp && moff == '0) moff = cfg.map_off_hold;
    end else begin
      moff = '0;
    end

    if (on_req) begin
      moff = '0;
      if (mon > MON_W'(signed'(2'sb01))) mon = mon - MON_W'(1);
      else mp = 1'b1;
    end else begin
      mon = '0;
      if (moff > TICK_W'(1)) moff = moff - TICK_W'(1);
      else mp = 1'b0;
    end

    tmr_o.hold    = ht;
    tmr_o.map_on  = mon;
    tmr_o.map_off = moff;
    flg_o.sec_on  = son;
    flg_o.map_on  = mp;
  end

endmodule

`default_nettype wire

### rtl/core/section_switch_delay_timers_core.sv
// Section switch and mapping delay timers.
// Input channel (in_valid / in_stall): one item per section request, with the
// section index, the on/off request and a frame-end flag.
// Result channel (out_valid / out_stall): one result per input item, in order,
// with the section's on and mapping flags, the mapping mask over sections 0..15
// and, on frame end, whether the mask changed since the previous frame end.
// Configuration: cfg_we / cfg_index / cfg_wdata, one register per write; write
// only while the block is idle (a rule for the user; the block does not enforce it).
// An accepted item waits in the stage-2 registers; its result is computed
// combinationally and loaded into the result register once that register is free.
// Throughput: 1 item per cycle unless out_stall holds the result. Per-section
// timers sit in a one-port-read, one-port-write memory with a registered read;
// the read is issued at accept, the write-back when the result is loaded, with one-entry forwarding.
// Reset (rst_n low, synchronous) clears all flags, timer valid bits, the
// previous mask and the registers to their reset values; no clearing pass.
// When out_stall holds the result register, the item behind it waits and
// in_stall rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module section_switch_delay_timers_core #(
  parameter int MAX_SECTIONS = ssdt_pkg::MAX_SECTIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ssdt_pkg::IDX_W-1:0]    in_section_index,
  input  wire logic                          in_on_request,
  input  wire logic                          in_frame_end,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_section_active,
  output logic                               out_mapping_active,
  output logic [ssdt_pkg::MASK_W-1:0]        out_mapping_mask,
  output logic                               out_mask_changed,
  input  wire logic                          cfg_we,
  input  wire logic [ssdt_pkg::CFG_A_W-1:0]  cfg_index,
  input  wire logic [ssdt_pkg::CFG_D_W-1:0]  cfg_wdata
);
  import ssdt_pkg::*;

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int MW = (MAX_SECTIONS < MASK_W) ? MAX_SECTIONS : MASK_W;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_hold_en    <= 1'b0;
      cfg_r.off_hold_ticks <= '0;
      cfg_r.map_on_ticks   <= '0;
      cfg_r.la_off_en      <= 1'b0;
      cfg_r.map_off_la     <= TICK_W'(4);
      cfg_r.map_off_hold   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_HOLD_EN:  cfg_r.off_hold_en    <= cfg_wdata[0];
        REG_OFF_HOLD_TK:  cfg_r.off_hold_ticks <= cfg_wdata[TICK_W-1:0];
        REG_MAP_ON_TK:    cfg_r.map_on_ticks   <= signed'(cfg_wdata[MON_W-1:0]);
        REG_LA_OFF_EN:    cfg_r.la_off_en      <= cfg_wdata[0];
        REG_MAP_OFF_LA:   cfg_r.map_off_la     <= cfg_wdata[TICK_W-1:0];
        REG_MAP_OFF_HOLD: cfg_r.map_off_hold   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  logic          in_acc;
  logic          in_inr;
  logic [AW-1:0] in_addr;

  logic          s2_vld_r;
  logic          s2_inr_r;
  logic [AW-1:0] s2_addr_r;
  logic          s2_on_r;
  logic          s2_fend_r;
  logic          s2_fire;

  tmr_t          mem [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] ent_vld_r;
  tmr_t          rd_r;
  logic          rd_vld_r;

  logic          wb_vld_r;
  logic [AW-1:0] wb_addr_r;
  tmr_t          wb_r;

  logic [MAX_SECTIONS-1:0] son_r;
  logic [MAX_SECTIONS-1:0] son_nxt;
  logic [MAX_SECTIONS-1:0] map_r;
  logic [MAX_SECTIONS-1:0] map_nxt;
  logic [MASK_W-1:0]       prev_mask_r;
  logic [MASK_W-1:0]       mask_nxt;

  tmr_t tmr_cur;
  tmr_t tmr_new;
  flg_t flg_cur;
  flg_t flg_new;

  assign s2_fire  = s2_vld_r && (!out_valid || !out_stall);
  assign in_stall = s2_vld_r && !s2_fire;
  assign in_acc   = in_valid && !in_stall;
  assign in_inr   = 32'(in_section_index) < MAX_SECTIONS;
  assign in_addr  = AW'(in_section_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (in_acc) begin
      s2_vld_r <= 1'b1;
    end else if (s2_fire) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_inr_r  <= in_inr;
      s2_addr_r <= in_addr;
      s2_on_r   <= in_on_request;
      s2_fend_r <= in_frame_end;
    end
  end

  // timer memory: read at accept, write back when the result is loaded
  always_ff @(posedge clk) begin
    if (in_acc && in_inr) begin
      rd_r <= mem[in_addr];
    end
    if (s2_fire && s2_inr_r) begin
      mem[s2_addr_r] <= tmr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      wb_vld_r  <= 1'b0;
    end else begin
      if (in_acc && in_inr) rd_vld_r <= ent_vld_r[in_addr];
      if (s2_fire && s2_inr_r) begin
        ent_vld_r[s2_addr_r] <= 1'b1;
        wb_vld_r             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_inr_r) begin
      wb_addr_r <= s2_addr_r;
      wb_r      <= tmr_new;
    end
  end

  always_comb begin
    if (wb_vld_r && wb_addr_r == s2_addr_r) tmr_cur = wb_r;
    else if (rd_vld_r) tmr_cur = rd_r;
    else tmr_cur = '0;
    flg_cur.sec_on = son_r[s2_addr_r];
    flg_cur.map_on = map_r[s2_addr_r];
  end

  ssdt_step u_step (
    .cfg    (cfg_r),
    .on_req (s2_on_r),
    .tmr_i  (tmr_cur),
    .flg_i  (flg_cur),
    .tmr_o  (tmr_new),
    .flg_o  (flg_new)
  );

  always_comb begin
    son_nxt = son_r;
    map_nxt = map_r;
    if (s2_inr_r) begin
      son_nxt[s2_addr_r] = flg_new.sec_on;
      map_nxt[s2_addr_r] = flg_new.map_on;
    end
    mask_nxt = '0;
    for (int j = 0; j < MW; j++) begin
      mask_nxt[j] = map_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      son_r       <= '0;
      map_r       <= '0;
      prev_mask_r <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s2_fire) begin
        son_r <= son_nxt;
        map_r <= map_nxt;
        if (s2_fend_r) prev_mask_r <= mask_nxt;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_section_active <= s2_inr_r && flg_new.sec_on;
      out_mapping_active <= s2_inr_r && flg_new.map_on;
      out_mapping_mask   <= mask_nxt;
      out_mask_changed   <= s2_fend_r && (mask_nxt != prev_mask_r);
    end
  end

endmodule

`default_nettype wire
